/* sv/ic_pkg.sv */
package ic_pkg;

  // array capacity, one cell per stored element
  localparam int MAX_ELEMS = 128;

  // field widths
  localparam int DATA_W = 32;
  localparam int COUNT_W = 13;
  localparam int IN_TDATA_W = ((DATA_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((COUNT_W + 7) / 8) * 8;

  // per-probe partial count, enough for every cell of the chain
  localparam int PCNT_W = $clog2(MAX_ELEMS + 1);

  // saturation limit of the running count
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // largest count a correct array can produce
  localparam int PAIR_ALL = (MAX_ELEMS * (MAX_ELEMS - 1)) / 2;
  localparam int PAIR_MAX = (PAIR_ALL > int'(COUNT_MAX)) ? int'(COUNT_MAX) : PAIR_ALL;

  // one element travelling down the cell chain
  typedef struct packed {
    logic                     valid;
    logic                     last;
    logic                     placed;  // found a free cell (stored, or would fit)
    logic signed [DATA_W-1:0] value;
    logic [PCNT_W-1:0]        cnt;     // stored elements greater than value so far
  } probe_t;

endpackage

/* sv/ic_cell.sv */
module ic_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  ic_pkg::probe_t probe_in,
  output ic_pkg::probe_t probe_out
);
  import ic_pkg::*;

  logic signed [DATA_W-1:0] elem;
  logic                     occupied;
  logic                     greater;
  logic                     capture;
  probe_t                   probe_next;

  // compare against the held element and claim the first free cell
  always_comb begin
    greater = probe_in.valid && occupied && (elem > probe_in.value);
    capture = probe_in.valid && !occupied && !probe_in.placed;
    probe_next = probe_in;
    probe_next.cnt = probe_in.cnt + PCNT_W'(greater);
    probe_next.placed = probe_in.placed || capture;
  end

  // occupancy: the final element of an array empties every cell it passes
  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= 1'b0;
      probe_out.valid <= 1'b0;
    end else if (adv) begin
      if (probe_in.valid && probe_in.last) begin
        occupied <= 1'b0;
      end else if (capture) begin
        occupied <= 1'b1;
      end
      probe_out.valid <= probe_next.valid;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      if (capture) begin
        elem <= probe_in.value;
      end
      probe_out.last <= probe_next.last;
      probe_out.placed <= probe_next.placed;
      probe_out.value <= probe_next.value;
      probe_out.cnt <= probe_next.cnt;
    end
  end

endmodule

/* sv/ic_collect.sv */
module ic_collect (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ic_pkg::probe_t                       tail,
  output logic                                 adv,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [ic_pkg::COUNT_W-1:0]           out_count,
  output logic                                 out_ovf
);
  import ic_pkg::*;

  logic [COUNT_W-1:0] running;
  logic               overflow;
  logic [COUNT_W:0]   sum;
  logic [COUNT_W-1:0] total;
  logic               ovf_next;
  logic               take;

  // chain stops only when a finished result would land on an unread one
  assign adv = !(tail.valid && tail.last && out_valid && !out_ready);
  assign take = adv && tail.valid;

  // accumulate only elements that found room, saturating
  always_comb begin
    sum = {1'b0, running} + (COUNT_W + 1)'(tail.placed ? tail.cnt : '0);
    total = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[COUNT_W-1:0];
    ovf_next = overflow || !tail.placed;
  end

  // running totals of the current array
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= '0;
      overflow <= 1'b0;
    end else if (take) begin
      if (tail.last) begin
        running <= '0;
        overflow <= 1'b0;
      end else begin
        running <= total;
        overflow <= ovf_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && tail.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && tail.last) begin
      out_count <= total;
      out_ovf <= ovf_next;
    end
  end

endmodule

/* sv/inversion_counter_top.sv */
// a result is registered at the output once its final element has passed all MAX_ELEMS cells
// throughput: one element per cycle unless stalled; each element walks the chain of
// MAX_ELEMS compare cells one cell per cycle, so later elements follow directly behind it
// the chain stalls only while a finished result waits on an unread one at the output
// reset clears every cell's occupancy bit, the totals and the output at once; no clearing pass
module inversion_counter_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [ic_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // [31:0] value
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [ic_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // [12:0] inversion_count, rest zero
  output logic                              m_axis_tuser    // [0] overflow
);
  import ic_pkg::*;

  probe_t             probes [0:MAX_ELEMS];
  logic               adv;
  logic [COUNT_W-1:0] out_count;

  assign s_axis_tready = adv;

  // new element enters the head of the chain
  always_comb begin
    probes[0].valid = s_axis_tvalid && adv;
    probes[0].last = s_axis_tlast;
    probes[0].placed = 1'b0;
    probes[0].value = s_axis_tdata[DATA_W-1:0];
    probes[0].cnt = '0;
  end

  // chain of compare cells
  for (genvar k = 0; k < MAX_ELEMS; k++) begin : g_cell
    ic_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .probe_in  (probes[k]),
      .probe_out (probes[k+1])
    );
  end

  // totals and result register
  ic_collect u_collect (
    .clk       (clk),
    .rst       (rst),
    .tail      (probes[MAX_ELEMS]),
    .adv       (adv),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_count (out_count),
    .out_ovf   (m_axis_tuser)
  );

  assign m_axis_tdata = OUT_TDATA_W'(out_count);

  // input back-pressure only comes from a blocked result
  a_ready_low_only_when_blocked : assert property (
    @(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready)
  ) else $error("input stalled without a blocked result");

  // a stalled chain keeps its tail element unchanged
  a_tail_holds_on_stall : assert property (
    @(posedge clk) disable iff (rst)
    !adv |=> (probes[MAX_ELEMS] == $past(probes[MAX_ELEMS]))
  ) else $error("tail element changed during stall");

  // a reported count never exceeds the number of pairs in a full array
  a_count_bound : assert property (
    @(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (int'(out_count) <= PAIR_MAX)
  ) else $error("inversion count out of range");

endmodule
